[sv/lsbt_pkg.sv]
// Shared types and constants for the lidar segment box tracker.
// Depends on nothing; every other file imports it.
`default_nettype none
package lsbt_pkg;

  localparam int COORD_W = 16;
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_LOST_TIMEOUT_MS = 1000;
  localparam int DEF_MIN_EXTENT_MM = 100;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GAP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINPTS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAB    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEP     = 3'd4;

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [COORD_W-1:0]  x_mm;
    logic signed [COORD_W-1:0]  y_mm;
    logic [31:0]                now_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  center_x_mm;
    logic signed [COORD_W-1:0]  center_y_mm;
    logic [COORD_W-1:0]         width_mm;
    logic [COORD_W-1:0]         height_mm;
    logic                       is_stable;
    logic                       last_entry;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] y1;
  } box_t;

  typedef struct packed {
    box_t        box;
    logic [31:0] born_ms;
    logic [31:0] seen_ms;
    logic        stable;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PT, S_CLOSE, S_WALK, S_SEP, S_DEC, S_FIN, S_AGE, S_EMIT
  } state_t;

endpackage
`default_nettype wire

[sv/lsbt_cell.sv]
// One slot of the tracking chain: holds an entry and takes its neighbour's on a shift.
// Depends on lsbt_pkg.
`default_nettype none
module lsbt_cell #(
  parameter int IW = 4,
  parameter int IDX = 0
) (
  input  wire                  clk,
  input  wire                  shift,
  input  wire                  wen,
  input  wire [IW-1:0]         wpos,
  input  lsbt_pkg::entry_t     nbr,
  input  lsbt_pkg::entry_t     wdata,
  output lsbt_pkg::entry_t     q
);
  import lsbt_pkg::*;

  localparam logic [IW-1:0] MY_POS = IW'(IDX);

  always_ff @(posedge clk) begin
    if (wen && wpos == MY_POS) begin
      q <= wdata;
    end else if (shift) begin
      q <= nbr;
    end
  end

endmodule
`default_nettype wire

[sv/lidar_segment_box_tracker.sv]
// Top level of the lidar segment box tracker: segmenter, sequencer and the chain of entry cells.
// Depends on lsbt_pkg and lsbt_cell.
//
//   channel | signals                     | direction
//   input   | in_valid, in_stall, in_data | words in, stall out
//   output  | out_valid, out_stall, out_data | words out, stall in
//   config  | cfg_wen, cfg_index, cfg_data | writes in
//
// A point is taken in S_IDLE and finished in S_PT; a scan start is handled in S_IDLE alone.
// Closing a segment that passes the filters walks the chain once, one entry a cycle.
// A scan end adds a second walk for ageing and then one emitted word per kept entry,
// paced by out_stall. Reset sets control and config state; entries are unread until written.
`default_nettype none
module lidar_segment_box_tracker #(
  parameter int TABLE_DEPTH = lsbt_pkg::DEF_TABLE_DEPTH,
  parameter int LOST_TIMEOUT_MS = lsbt_pkg::DEF_LOST_TIMEOUT_MS,
  parameter int MIN_EXTENT_MM = lsbt_pkg::DEF_MIN_EXTENT_MM
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  lsbt_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output lsbt_pkg::out_word_t            out_data,
  input  wire                            cfg_wen,
  input  wire [lsbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [lsbt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsbt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic signed [COORD_W:0] MIN_EXT = (COORD_W+1)'(MIN_EXTENT_MM);
  localparam logic signed [31:0] LOST_C = 32'(LOST_TIMEOUT_MS);

  state_t state, state_next;

  logic [14:0] gap_mm;
  logic [7:0]  min_pts;
  logic [14:0] wall_mm;
  logic [15:0] stab_ms;
  logic [15:0] sep_mm;
  logic [29:0] g2;
  logic [33:0] lim;

  logic [31:0] scan_time;
  logic signed [COORD_W-1:0] prev_x, prev_y, pt_x, pt_y;
  box_t seg;
  logic [7:0] seg_count;
  logic has_pts, end_pending;
  logic [33:0] sqx, sqy;
  logic [CW-1:0] n, k, m;
  logic matched, sep_hit, sq_valid;
  logic [35:0] ssx, ssy;

  logic shift, wen;
  logic [IW-1:0] wpos;
  entry_t wdata, head;
  entry_t cell_q [TABLE_DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_chain
      entry_t nbr;
      if (gi == TABLE_DEPTH - 1) begin : g_last
        assign nbr = cell_q[gi];
      end else begin : g_mid
        assign nbr = cell_q[gi+1];
      end
      lsbt_cell #(.IW(IW), .IDX(gi)) u_cell (
        .clk(clk), .shift(shift), .wen(wen), .wpos(wpos),
        .nbr(nbr), .wdata(wdata), .q(cell_q[gi])
      );
    end
  endgenerate

  assign head = cell_q[0];

  // Segment filters.
  logic signed [COORD_W:0] seg_w, seg_h, seg_wc, seg_hc, seg_min;
  logic pass;
  always_comb begin
    seg_w = {seg.x1[COORD_W-1], seg.x1} - {seg.x0[COORD_W-1], seg.x0};
    seg_h = {seg.y1[COORD_W-1], seg.y1} - {seg.y0[COORD_W-1], seg.y0};
    seg_wc = (seg_w < MIN_EXT) ? MIN_EXT : seg_w;
    seg_hc = (seg_h < MIN_EXT) ? MIN_EXT : seg_h;
    seg_min = (seg_wc < seg_hc) ? seg_wc : seg_hc;
    pass = (seg_count >= min_pts) && (seg_min >= $signed({2'b00, wall_mm}));
  end

  // Head entry against the closing segment.
  logic in_ce, in_ec, ovl;
  logic signed [COORD_W+1:0] hdx, hdy;
  logic [COORD_W:0] hax, hay;
  entry_t walk_upd;
  always_comb begin
    in_ce = (seg.x0 >= head.box.x0 && seg.x1 <= head.box.x1) ||
            (seg.y0 >= head.box.y0 && seg.y1 <= head.box.y1);
    in_ec = (head.box.x0 >= seg.x0 && head.box.x1 <= seg.x1) ||
            (head.box.y0 >= seg.y0 && head.box.y1 <= seg.y1);
    ovl = head.box.x0 <= seg.x1 && head.box.x1 >= seg.x0 &&
          head.box.y0 <= seg.y1 && head.box.y1 >= seg.y0;
    hdx = ((COORD_W+2)'(seg.x0) + (COORD_W+2)'(seg.x1)) -
          ((COORD_W+2)'(head.box.x0) + (COORD_W+2)'(head.box.x1));
    hdy = ((COORD_W+2)'(seg.y0) + (COORD_W+2)'(seg.y1)) -
          ((COORD_W+2)'(head.box.y0) + (COORD_W+2)'(head.box.y1));
    hax = hdx[COORD_W+1] ? (COORD_W+1)'(-hdx) : (COORD_W+1)'(hdx);
    hay = hdy[COORD_W+1] ? (COORD_W+1)'(-hdy) : (COORD_W+1)'(hdy);
    walk_upd = head;
    if (!matched) begin
      if (in_ce || ovl) begin
        walk_upd.seen_ms = scan_time;
      end
      if (!in_ce && in_ec) begin
        walk_upd.box = seg;
        walk_upd.seen_ms = scan_time;
        walk_upd.stable = 1'b1;
      end
    end
  end

  // Ageing of the head entry.
  logic signed [31:0] d_first, d_last;
  logic kept;
  entry_t aged;
  always_comb begin
    d_first = $signed(scan_time - head.born_ms);
    d_last = $signed(scan_time - head.seen_ms);
    aged = head;
    if (d_first > $signed({16'b0, stab_ms})) begin
      aged.stable = 1'b1;
    end
    kept = !(d_last > LOST_C);
  end

  // Result word from the head entry.
  out_word_t emit;
  logic signed [COORD_W:0] sxs, sys, ewx, ewy;
  always_comb begin
    sxs = {head.box.x0[COORD_W-1], head.box.x0} + {head.box.x1[COORD_W-1], head.box.x1};
    sys = {head.box.y0[COORD_W-1], head.box.y0} + {head.box.y1[COORD_W-1], head.box.y1};
    ewx = {head.box.x1[COORD_W-1], head.box.x1} - {head.box.x0[COORD_W-1], head.box.x0};
    ewy = {head.box.y1[COORD_W-1], head.box.y1} - {head.box.y0[COORD_W-1], head.box.y0};
    if (ewx < MIN_EXT) ewx = MIN_EXT;
    if (ewy < MIN_EXT) ewy = MIN_EXT;
    emit.center_x_mm = sxs[COORD_W:1];
    emit.center_y_mm = sys[COORD_W:1];
    emit.width_mm = ewx[COORD_W-1:0];
    emit.height_mm = ewy[COORD_W-1:0];
    emit.is_stable = head.stable;
    emit.last_entry = (k == n - ONE_C);
  end

  logic gap_hit, out_free, can_add;
  entry_t new_entry;
  always_comb begin
    gap_hit = ({1'b0, sqx} + {1'b0, sqy}) > {5'b0, g2};
    out_free = !out_valid || !out_stall;
    can_add = !matched && !sep_hit && (n < DEPTH_C);
    new_entry.box = seg;
    new_entry.born_ms = scan_time;
    new_entry.seen_ms = scan_time;
    new_entry.stable = 1'b0;
  end

  always_comb begin
    state_next = state;
    in_stall = (state != S_IDLE);
    shift = 1'b0;
    wen = 1'b0;
    wpos = '0;
    wdata = walk_upd;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_POINT) begin
            state_next = S_PT;
          end else if (in_data.kind == KIND_END && has_pts) begin
            state_next = S_CLOSE;
          end
        end
      end
      S_PT: begin
        state_next = (has_pts && gap_hit) ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        if (!pass) begin
          state_next = S_FIN;
        end else begin
          state_next = (n == '0) ? S_SEP : S_WALK;
        end
      end
      S_WALK: begin
        shift = 1'b1;
        wen = 1'b1;
        wpos = IW'(n - ONE_C);
        wdata = walk_upd;
        if (k == n - ONE_C) state_next = S_SEP;
      end
      S_SEP: begin
        state_next = S_DEC;
      end
      S_DEC: begin
        wen = can_add;
        wpos = IW'(n);
        wdata = new_entry;
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = (end_pending && n != '0) ? S_AGE : S_IDLE;
      end
      S_AGE: begin
        shift = 1'b1;
        wen = kept;
        wpos = IW'(n - ONE_C - k + m);
        wdata = aged;
        if (k == n - ONE_C) begin
          state_next = (m == '0 && !kept) ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          shift = 1'b1;
          wen = 1'b1;
          wpos = IW'(n - ONE_C);
          wdata = head;
          if (k == n - ONE_C) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    g2 <= 30'(gap_mm * gap_mm);
    lim <= {2'(0), 32'(sep_mm * sep_mm)} << 2;
    if (rst) begin
      gap_mm <= 15'd2500;
      min_pts <= 8'd8;
      wall_mm <= 15'd300;
      stab_ms <= 16'd3000;
      sep_mm <= 16'd5000;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_GAP:    gap_mm <= cfg_data[14:0];
        REG_MINPTS: min_pts <= cfg_data[7:0];
        REG_WALL:   wall_mm <= cfg_data[14:0];
        REG_STAB:   stab_ms <= cfg_data;
        REG_SEP:    sep_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [COORD_W:0] pdx, pdy;
  logic [COORD_W-1:0] pax, pay;
  always_comb begin
    pdx = {in_data.x_mm[COORD_W-1], in_data.x_mm} - {prev_x[COORD_W-1], prev_x};
    pdy = {in_data.y_mm[COORD_W-1], in_data.y_mm} - {prev_y[COORD_W-1], prev_y};
    pax = pdx[COORD_W] ? COORD_W'(-pdx) : COORD_W'(pdx);
    pay = pdy[COORD_W] ? COORD_W'(-pdy) : COORD_W'(pdy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_time <= '0;
      prev_x <= '0;
      prev_y <= '0;
      seg <= '0;
      seg_count <= '0;
      has_pts <= 1'b0;
      end_pending <= 1'b0;
      n <= '0;
      k <= '0;
      m <= '0;
      matched <= 1'b0;
      sep_hit <= 1'b0;
      sq_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == S_EMIT && out_free) || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.kind == KIND_START) begin
              scan_time <= in_data.now_ms;
              has_pts <= 1'b0;
              seg_count <= '0;
            end else if (in_data.kind == KIND_POINT) begin
              pt_x <= in_data.x_mm;
              pt_y <= in_data.y_mm;
              sqx <= 34'(pax) * 34'(pax);
              sqy <= 34'(pay) * 34'(pay);
            end else if (in_data.kind == KIND_END && has_pts) begin
              end_pending <= 1'b1;
            end
          end
        end
        S_PT: begin
          prev_x <= pt_x;
          prev_y <= pt_y;
          if (!has_pts) begin
            seg <= '{pt_x, pt_x, pt_y, pt_y};
            seg_count <= 8'd1;
            has_pts <= 1'b1;
          end else if (gap_hit) begin
            end_pending <= 1'b0;
          end else begin
            if (pt_x < seg.x0) seg.x0 <= pt_x;
            if (pt_x > seg.x1) seg.x1 <= pt_x;
            if (pt_y < seg.y0) seg.y0 <= pt_y;
            if (pt_y > seg.y1) seg.y1 <= pt_y;
            if (seg_count != 8'hFF) seg_count <= seg_count + 8'd1;
          end
        end
        S_CLOSE: begin
          k <= '0;
          matched <= 1'b0;
          sep_hit <= 1'b0;
          sq_valid <= 1'b0;
        end
        S_WALK: begin
          if (!matched && (in_ce || in_ec || ovl)) matched <= 1'b1;
          ssx <= 36'(hax) * 36'(hax);
          ssy <= 36'(hay) * 36'(hay);
          sq_valid <= head.stable;
          if (sq_valid && ({1'b0, ssx} + {1'b0, ssy}) < {3'b0, lim}) sep_hit <= 1'b1;
          k <= k + ONE_C;
        end
        S_SEP: begin
          if (sq_valid && ({1'b0, ssx} + {1'b0, ssy}) < {3'b0, lim}) sep_hit <= 1'b1;
          sq_valid <= 1'b0;
        end
        S_DEC: begin
          if (can_add) n <= n + ONE_C;
        end
        S_FIN: begin
          k <= '0;
          m <= '0;
          if (end_pending) begin
            has_pts <= 1'b0;
            seg_count <= '0;
            end_pending <= 1'b0;
          end else begin
            seg <= '{pt_x, pt_x, pt_y, pt_y};
            seg_count <= 8'd1;
          end
        end
        S_AGE: begin
          if (kept) m <= m + ONE_C;
          if (k == n - ONE_C) begin
            n <= m + (kept ? ONE_C : '0);
            k <= '0;
          end else begin
            k <= k + ONE_C;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data <= emit;
            k <= k + ONE_C;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/lidar_segment_box_tracker_tb.sv]
// Self-checking testbench for the lidar segment box tracker: directed and random scans,
// random idling on both channels, and a scoreboard that predicts every emitted box.
// Depends on lsbt_pkg and the lidar_segment_box_tracker RTL.
module lidar_segment_box_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsbt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 120;

  class box_tracker_scoreboard;
    typedef struct {
      longint x0;
      longint x1;
      longint y0;
      longint y1;
    } rect_t;

    bit [14:0] gap_mm;
    bit [7:0] min_points;
    bit [14:0] wall_mm;
    bit [15:0] stab_ms;
    bit [15:0] sep_mm;
    bit [31:0] scan_time;
    longint prev_x;
    longint prev_y;
    rect_t seg;
    int seg_points;
    bit has_points;
    rect_t tbox[DEF_TABLE_DEPTH];
    bit [31:0] tfirst[DEF_TABLE_DEPTH];
    bit [31:0] tlast[DEF_TABLE_DEPTH];
    bit tstable[DEF_TABLE_DEPTH];
    int tcount;
    out_word_t boxes_due[$];
    int failures;

    function new();
      gap_mm = 2500;
      min_points = 8;
      wall_mm = 300;
      stab_ms = 3000;
      sep_mm = 5000;
      scan_time = 0;
      prev_x = 0;
      prev_y = 0;
      seg = '{0, 0, 0, 0};
      seg_points = 0;
      has_points = 0;
      tcount = 0;
      failures = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_GAP: gap_mm = v[14:0];
        REG_MINPTS: min_points = v[7:0];
        REG_WALL: wall_mm = v[14:0];
        REG_STAB: stab_ms = v;
        REG_SEP: sep_mm = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return boxes_due.size();
    endfunction

    function longint span(longint lo, longint hi);
      return (hi - lo < DEF_MIN_EXTENT_MM) ? DEF_MIN_EXTENT_MM : hi - lo;
    endfunction

    function longint age(bit [31:0] now, bit [31:0] then);
      bit [31:0] d;
      d = now - then;
      return longint'($signed(d));
    endfunction

    function bit holds(rect_t a, rect_t b);
      return (a.x0 >= b.x0 && a.x1 <= b.x1) || (a.y0 >= b.y0 && a.y1 <= b.y1);
    endfunction

    function bit touches(rect_t a, rect_t b);
      return b.x0 <= a.x1 && b.x1 >= a.x0 && b.y0 <= a.y1 && b.y1 >= a.y0;
    endfunction

    function void start_seg(longint x, longint y);
      seg = '{x, x, y, y};
      seg_points = 1;
    endfunction

    function void close_seg();
      longint w, h, dx, dy, lim;
      if (seg_points < min_points) return;
      w = span(seg.x0, seg.x1);
      h = span(seg.y0, seg.y1);
      if ((w < h ? w : h) < longint'(wall_mm)) return;
      for (int i = 0; i < tcount; i++) begin
        if (holds(seg, tbox[i])) begin
          tlast[i] = scan_time;
          return;
        end
        if (holds(tbox[i], seg)) begin
          tbox[i] = seg;
          tlast[i] = scan_time;
          tstable[i] = 1;
          return;
        end
        if (touches(seg, tbox[i])) begin
          tlast[i] = scan_time;
          return;
        end
      end
      lim = 4 * longint'(sep_mm) * longint'(sep_mm);
      for (int i = 0; i < tcount; i++) begin
        if (tstable[i]) begin
          dx = (seg.x0 + seg.x1) - (tbox[i].x0 + tbox[i].x1);
          dy = (seg.y0 + seg.y1) - (tbox[i].y0 + tbox[i].y1);
          if (dx * dx + dy * dy < lim) return;
        end
      end
      if (tcount < DEF_TABLE_DEPTH) begin
        tbox[tcount] = seg;
        tfirst[tcount] = scan_time;
        tlast[tcount] = scan_time;
        tstable[tcount] = 0;
        tcount++;
      end
    endfunction

    function void note_word(in_word_t w);
      longint x, y, dx, dy;
      int kept;
      out_word_t o;
      if (w.kind == KIND_START) begin
        scan_time = w.now_ms;
        has_points = 0;
        seg_points = 0;
      end else if (w.kind == KIND_POINT) begin
        x = longint'($signed(w.x_mm));
        y = longint'($signed(w.y_mm));
        if (!has_points) begin
          start_seg(x, y);
          has_points = 1;
        end else begin
          dx = x - prev_x;
          dy = y - prev_y;
          if (dx * dx + dy * dy > longint'(gap_mm) * longint'(gap_mm)) begin
            close_seg();
            start_seg(x, y);
          end else begin
            if (x < seg.x0) seg.x0 = x;
            if (x > seg.x1) seg.x1 = x;
            if (y < seg.y0) seg.y0 = y;
            if (y > seg.y1) seg.y1 = y;
            if (seg_points < 255) seg_points++;
          end
        end
        prev_x = x;
        prev_y = y;
      end else if (w.kind == KIND_END && has_points) begin
        close_seg();
        has_points = 0;
        seg_points = 0;
        kept = 0;
        for (int i = 0; i < tcount; i++) begin
          if (!tstable[i] && age(scan_time, tfirst[i]) > longint'(stab_ms)) tstable[i] = 1;
          if (age(scan_time, tlast[i]) > DEF_LOST_TIMEOUT_MS) continue;
          tbox[kept] = tbox[i];
          tfirst[kept] = tfirst[i];
          tlast[kept] = tlast[i];
          tstable[kept] = tstable[i];
          kept++;
        end
        tcount = kept;
        for (int i = 0; i < kept; i++) begin
          o.center_x_mm = 16'((tbox[i].x0 + tbox[i].x1) >>> 1);
          o.center_y_mm = 16'((tbox[i].y0 + tbox[i].y1) >>> 1);
          o.width_mm = 16'(span(tbox[i].x0, tbox[i].x1));
          o.height_mm = 16'(span(tbox[i].y0, tbox[i].y1));
          o.is_stable = tstable[i];
          o.last_entry = (i == kept - 1);
          boxes_due = {boxes_due, o};
        end
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      bit bad;
      if (boxes_due.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected box word: %p", got);
        return;
      end
      want = boxes_due.pop_front();
      bad = (got.center_x_mm !== want.center_x_mm) || (got.center_y_mm !== want.center_y_mm)
          || (got.width_mm !== want.width_mm) || (got.height_mm !== want.height_mm)
          || (got.is_stable !== want.is_stable) || (got.last_entry !== want.last_entry);
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display("box mismatch: expected cx %0d cy %0d w %0d h %0d st %0b last %0b",
                   want.center_x_mm, want.center_y_mm, want.width_mm, want.height_mm,
                   want.is_stable, want.last_entry);
          $display("              got      cx %0d cy %0d w %0d h %0d st %0b last %0b",
                   got.center_x_mm, got.center_y_mm, got.width_mm, got.height_mm,
                   got.is_stable, got.last_entry);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  box_tracker_scoreboard sb;
  bit idle_in;
  bit idle_out;
  bit hold_req;
  int cycles;
  bit [31:0] now_t;
  int ox[4];
  int oy[4];
  int osx[4];
  int osy[4];

  lidar_segment_box_tracker uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(out_data);
  end

  initial begin
    out_stall <= 0;
    forever begin
      if (hold_req) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_req = 0;
        out_stall <= 0;
        @(posedge clk);
      end else if (idle_out && $urandom_range(0, 2) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send(in_word_t w);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  task automatic send_start(bit [31:0] t);
    in_word_t w;
    w.kind = KIND_START;
    w.x_mm = 16'($urandom);
    w.y_mm = 16'($urandom);
    w.now_ms = t;
    send(w);
  endtask

  task automatic send_point(int x, int y);
    in_word_t w;
    w.kind = KIND_POINT;
    w.x_mm = 16'(x);
    w.y_mm = 16'(y);
    w.now_ms = $urandom;
    send(w);
  endtask

  task automatic send_raw(logic [1:0] k);
    in_word_t w;
    w.kind = k;
    w.x_mm = 16'($urandom);
    w.y_mm = 16'($urandom);
    w.now_ms = $urandom;
    send(w);
  endtask

  task automatic cluster(int cx, int cy, int sx, int sy, int n);
    for (int i = 0; i < n; i++)
      send_point(cx + $urandom_range(0, sx) - sx / 2, cy + $urandom_range(0, sy) - sy / 2);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(int gap, int minpts, int wall, int stab, int sep);
    int vals[5];
    vals = '{gap, minpts, wall, stab, sep};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_wen <= 1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      sb.set_reg(CFG_IDX_W'(i), CFG_DATA_W'(vals[i]));
    end
    cfg_wen <= 0;
  endtask

  task automatic random_scan();
    int k;
    now_t += $urandom_range(100, 700);
    if ($urandom_range(0, 7) == 0) now_t += $urandom_range(1500, 4000);
    send_start(now_t);
    for (int c = 0; c < 2; c++) begin
      k = $urandom_range(0, 3);
      cluster(ox[k] + $urandom_range(0, 600) - 300, oy[k] + $urandom_range(0, 600) - 300,
              osx[k] + $urandom_range(0, 400), osy[k] + $urandom_range(0, 400),
              $urandom_range(4, 5));
      if ($urandom_range(0, 7) == 0) send_point($urandom, $urandom);
      if ($urandom_range(0, 7) == 0) send_raw(KIND_UNUSED);
    end
    send_raw(KIND_END);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst <= 1;
    in_valid <= 0;
    in_data <= '0;
    cfg_wen <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    idle_in = 1;
    idle_out = 1;
    hold_req = 0;
    now_t = 32'hFFFF_F000 + $urandom_range(0, 2000);
    for (int k = 0; k < 4; k++) begin
      ox[k] = -24000 + k * 16000;
      oy[k] = $urandom_range(0, 50000) - 25000;
      osx[k] = $urandom_range(200, 1200);
      osy[k] = $urandom_range(200, 1200);
    end
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: orphan points, undefined kind, empty and repeated scan ends, extremes, walls.
    send_point(10, 20);
    send_point(30, 40);
    send_raw(KIND_END);
    send_raw(KIND_UNUSED);
    send_start(now_t);
    send_raw(KIND_END);
    send_raw(KIND_END);
    send_start(now_t);
    send_point(-32768, 32767);
    cluster(-32700, 32700, 120, 120, 7);
    send_point(32767, -32768);
    cluster(32700, -32700, 120, 120, 7);
    send_raw(KIND_END);
    send_raw(KIND_END);

    // Low extremes: every point is its own box, so the table fills and then ages out.
    write_regs(0, 1, 0, 0, 0);
    now_t += 200;
    send_start(now_t);
    for (int i = 0; i < 17; i++) send_point(i * 3500 - 28000, i * 2500 - 20000);
    send_raw(KIND_END);
    now_t += 1500;
    send_start(now_t);
    send_point(0, 0);
    send_raw(KIND_END);

    // High extremes: one long sweep that stays below the point count.
    write_regs(32767, 255, 32767, 65535, 65535);
    now_t += 300;
    send_start(now_t);
    for (int i = 0; i < 10; i++) send_point(-17000 + i * 3100, -17000 + i * 3100 + (i % 2) * 50);
    send_raw(KIND_END);

    write_regs(2500, 4, 150, 600, 5000);
    random_scan();
    hold_req = 1;
    for (int s = 0; s < 2; s++) random_scan();
    wait_idle();
    random_scan();
    idle_in = 0;
    idle_out = 0;
    random_scan();

    in_valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
